### sv/minv_pkg.sv
package minv_pkg;

   localparam int ElemWidth   = 32;
   localparam int ProdWidth   = 64;
   localparam int TriWidth    = 96;
   localparam int DetWidth    = 98;
   localparam int CofWidth    = 65;
   localparam int NumWidth    = 96;
   localparam int QuotWidth   = 97;
   localparam int ThreshWidth = 64;
   localparam int NumElems    = 9;
   localparam int NumTerms    = 6;
   localparam logic [ThreshWidth-1:0] ThreshReset = 64'd281;

   typedef logic signed [ElemWidth-1:0] elem_type;

   typedef struct packed {
      elem_type m00;
      elem_type m01;
      elem_type m02;
      elem_type m10;
      elem_type m11;
      elem_type m12;
      elem_type m20;
      elem_type m21;
      elem_type m22;
   } matrix_type;

   typedef struct packed {
      elem_type   inv00;
      elem_type   inv01;
      elem_type   inv02;
      elem_type   inv10;
      elem_type   inv11;
      elem_type   inv12;
      elem_type   inv20;
      elem_type   inv21;
      elem_type   inv22;
      logic       singular;
   } inverse_type;

endpackage

### sv/minv_if.sv
interface minv_req_if;
   logic                   valid;
   logic                   ready;
   minv_pkg::matrix_type   data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface minv_rsp_if;
   logic                   valid;
   logic                   ready;
   minv_pkg::inverse_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### sv/matrix_inverse_3x3_unit.sv
// channel | dir | handshake     | payload
// req     | in  | valid/ready   | m00..m22, signed Q16.16
// rsp     | out | valid/ready   | inv00..inv22 Q16.16, singular
// csr     | in  | write enable  | singular_threshold, 64 bits
//
// one item per cycle while the pipe advances; 104 register stages:
// 5 for products, cofactors, determinant and magnitudes, 98 in the divider
// (a load and one per quotient bit) and the output register
// reset is synchronous and clears the valid bits and the threshold to 281
// the whole pipe advances when the output stage is empty or being taken,
// so a stall holds every stage and nothing is lost or repeated
module matrix_inverse_3x3_unit (
   input  logic                           clock,
   input  logic                           reset,
   minv_req_if.sink                       req,
   minv_rsp_if.source                     rsp,
   input  logic                           csr_write,
   input  logic [minv_pkg::ThreshWidth-1:0] csr_wdata
);
   localparam int EW = minv_pkg::ElemWidth;
   localparam int PW = minv_pkg::ProdWidth;
   localparam int TW = minv_pkg::TriWidth;
   localparam int DW = minv_pkg::DetWidth;
   localparam int CW = minv_pkg::CofWidth;
   localparam int NE = minv_pkg::NumElems;

   logic [minv_pkg::ThreshWidth-1:0] thresh_ff;
   logic advance;
   logic out_valid_ff;
   minv_pkg::inverse_type out_ff;

   always_ff @(posedge clock) begin
      if (reset) thresh_ff <= minv_pkg::ThreshReset;
      else if (csr_write) thresh_ff <= csr_wdata;
   end

   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = advance;

   // stage 1: pair products for cofactors and for determinant terms
   logic                         v1_ff;
   logic signed [2:0][EW-1:0]    e1_ff;
   logic signed [PW-1:0]         p1_ff [18];
   logic signed [EW-1:0]         s [NE];
   assign s[0] = req.data.m00; assign s[1] = req.data.m01; assign s[2] = req.data.m02;
   assign s[3] = req.data.m10; assign s[4] = req.data.m11; assign s[5] = req.data.m12;
   assign s[6] = req.data.m20; assign s[7] = req.data.m21; assign s[8] = req.data.m22;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (advance) v1_ff <= req.valid;
      if (advance) begin
         p1_ff[0]  <= s[4] * s[8]; p1_ff[1]  <= s[5] * s[7];
         p1_ff[2]  <= s[2] * s[7]; p1_ff[3]  <= s[1] * s[8];
         p1_ff[4]  <= s[1] * s[5]; p1_ff[5]  <= s[2] * s[4];
         p1_ff[6]  <= s[5] * s[6]; p1_ff[7]  <= s[3] * s[8];
         p1_ff[8]  <= s[0] * s[8]; p1_ff[9]  <= s[2] * s[6];
         p1_ff[10] <= s[2] * s[3]; p1_ff[11] <= s[0] * s[5];
         p1_ff[12] <= s[3] * s[7]; p1_ff[13] <= s[4] * s[6];
         p1_ff[14] <= s[1] * s[6]; p1_ff[15] <= s[0] * s[7];
         p1_ff[16] <= s[0] * s[4]; p1_ff[17] <= s[1] * s[3];
         e1_ff <= {s[6], s[7], s[8]};
      end
   end

   // stage 2: cofactors; triple products split into two 64x16-ish halves
   logic                 v2_ff;
   logic signed [CW-1:0] cof2_ff [NE];
   logic signed [TW-1:0] lo2_ff [minv_pkg::NumTerms];
   logic signed [TW-1:0] hi2_ff [minv_pkg::NumTerms];
   logic signed [PW-1:0] tp [minv_pkg::NumTerms];
   logic signed [EW-1:0] tf [minv_pkg::NumTerms];
   // det terms: s0 s4 s8, s1 s5 s6, s2 s3 s7, minus s2 s4 s6, s0 s5 s7, s1 s3 s8
   assign tp[0] = p1_ff[16]; assign tf[0] = e1_ff[0];
   assign tp[1] = p1_ff[4];  assign tf[1] = e1_ff[2];
   assign tp[2] = p1_ff[10]; assign tf[2] = e1_ff[1];
   assign tp[3] = p1_ff[5];  assign tf[3] = e1_ff[2];
   assign tp[4] = p1_ff[11]; assign tf[4] = e1_ff[1];
   assign tp[5] = p1_ff[17]; assign tf[5] = e1_ff[0];

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (advance) v2_ff <= v1_ff;
      if (advance) begin
         for (int c = 0; c < NE; c++) begin
            cof2_ff[c] <= CW'(p1_ff[2*c]) - CW'(p1_ff[2*c+1]);
         end
         for (int t = 0; t < minv_pkg::NumTerms; t++) begin
            lo2_ff[t] <= tp[t] * $signed({1'b0, tf[t][15:0]});
            hi2_ff[t] <= tp[t] * $signed(tf[t][31:16]);
         end
      end
   end

   // stage 3: recombine triple products
   logic                 v3_ff;
   logic signed [CW-1:0] cof3_ff [NE];
   logic signed [TW-1:0] tri3_ff [minv_pkg::NumTerms];
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (advance) v3_ff <= v2_ff;
      if (advance) begin
         cof3_ff <= cof2_ff;
         for (int t = 0; t < minv_pkg::NumTerms; t++) begin
            tri3_ff[t] <= lo2_ff[t] + (hi2_ff[t] <<< 16);
         end
      end
   end

   // stage 4: determinant
   logic                 v4_ff;
   logic signed [CW-1:0] cof4_ff [NE];
   logic signed [DW-1:0] det4_ff;
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (advance) v4_ff <= v3_ff;
      if (advance) begin
         cof4_ff <= cof3_ff;
         det4_ff <= DW'(tri3_ff[0]) + DW'(tri3_ff[1]) + DW'(tri3_ff[2])
                  - DW'(tri3_ff[3]) - DW'(tri3_ff[4]) - DW'(tri3_ff[5]);
      end
   end

   // stage 5: magnitudes, signs and singular test
   logic                                       v5_ff;
   logic                                       sng5_ff;
   logic [NE-1:0]                              neg5_ff;
   logic [NE-1:0][minv_pkg::NumWidth-1:0]      num5_ff;
   logic [DW-1:0]                              den5_ff;
   logic [DW-1:0]                              adet;
   logic [CW-1:0]                              acof [NE];
   assign adet = det4_ff[DW-1] ? DW'(-det4_ff) : DW'(det4_ff);

   // cofactor magnitudes always fit in 64 bits
   always_comb begin
      for (int c = 0; c < NE; c++) begin
         acof[c] = cof4_ff[c][CW-1] ? CW'(-cof4_ff[c]) : CW'(cof4_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (advance) v5_ff <= v4_ff;
      if (advance) begin
         sng5_ff <= adet <= DW'(thresh_ff);
         // keep a nonzero divisor when singular, result is masked anyway
         den5_ff <= (adet <= DW'(thresh_ff)) ? DW'(1) : adet;
         for (int c = 0; c < NE; c++) begin
            neg5_ff[c] <= cof4_ff[c][CW-1] != det4_ff[DW-1];
            num5_ff[c] <= {acof[c][CW-2:0], 32'd0};
         end
      end
   end

   logic                   dv;
   logic                   dsng;
   logic [NE-1:0][EW-1:0]  dq;
   minv_divider #(.Lanes(NE)) u_div (
      .clock, .reset, .advance,
      .in_valid(v5_ff), .in_sing(sng5_ff), .in_neg(neg5_ff),
      .in_num(num5_ff), .in_den(den5_ff),
      .out_valid(dv), .out_sing(dsng), .out_q(dq)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (advance) out_valid_ff <= dv;
      if (advance) begin
         out_ff <= {dq[0], dq[1], dq[2], dq[3], dq[4], dq[5], dq[6], dq[7], dq[8], dsng};
      end
   end
   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("output changed under stall");
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.data.singular |-> rsp.data.inv00 == 0 && rsp.data.inv22 == 0)
      else $error("singular item with nonzero output");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("input stalled with empty output");
endmodule

### sv/minv_divider.sv
// restoring divider, one quotient bit per stage, nine lanes in parallel
// |quotient| of |num| / |den| (num arrives already shifted left by 32), saturated on exit
module minv_divider #(
   parameter int Lanes = minv_pkg::NumElems
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  logic                                   in_valid,
   input  logic                                   in_sing,
   input  logic [Lanes-1:0]                       in_neg,
   input  logic [Lanes-1:0][minv_pkg::NumWidth-1:0] in_num,
   input  logic [minv_pkg::DetWidth-1:0]          in_den,
   output logic                                   out_valid,
   output logic                                   out_sing,
   output logic [Lanes-1:0][minv_pkg::ElemWidth-1:0] out_q
);
   localparam int Steps = minv_pkg::QuotWidth;
   localparam int RW    = minv_pkg::DetWidth + 1;
   localparam int NW    = minv_pkg::NumWidth;

   logic [Steps:0]                          vld_ff;
   logic [Steps:0]                          sng_ff;
   logic [Steps:0][Lanes-1:0]               neg_ff;
   logic [Steps:0][minv_pkg::DetWidth-1:0]  den_ff;
   logic [Steps:0][Lanes-1:0][RW-1:0]       rem_ff;
   logic [Steps:0][Lanes-1:0][NW-1:0]       num_ff;
   logic [Steps:0][Lanes-1:0][Steps-1:0]    quo_ff;

   // stage zero load
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
      end
      if (advance) begin
         sng_ff[0] <= in_sing;
         neg_ff[0] <= in_neg;
         den_ff[0] <= in_den;
         for (int l = 0; l < Lanes; l++) begin
            rem_ff[0][l] <= '0;
            num_ff[0][l] <= in_num[l];
            quo_ff[0][l] <= '0;
         end
      end
   end

   // one quotient bit per stage; numerator bits above NumWidth are zero
   for (genvar s = 0; s < Steps; s++) begin : g_step
      logic [Lanes-1:0][RW-1:0]    rem_in;
      logic [Lanes-1:0][NW-1:0]    num_in;
      logic [Lanes-1:0][Steps-1:0] quo_in;
      always_comb begin
         for (int l = 0; l < Lanes; l++) begin
            logic [RW-1:0] trial;
            trial     = {rem_ff[s][l][RW-2:0], (s >= Steps - NW) ? num_ff[s][l][NW-1] : 1'b0};
            num_in[l] = (s >= Steps - NW) ? {num_ff[s][l][NW-2:0], 1'b0} : num_ff[s][l];
            if (trial >= {1'b0, den_ff[s]}) begin
               rem_in[l] = trial - {1'b0, den_ff[s]};
               quo_in[l] = {quo_ff[s][l][Steps-2:0], 1'b1};
            end else begin
               rem_in[l] = trial;
               quo_in[l] = {quo_ff[s][l][Steps-2:0], 1'b0};
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[s+1] <= vld_ff[s];
         end
         if (advance) begin
            sng_ff[s+1] <= sng_ff[s];
            neg_ff[s+1] <= neg_ff[s];
            den_ff[s+1] <= den_ff[s];
            rem_ff[s+1] <= rem_in;
            num_ff[s+1] <= num_in;
            quo_ff[s+1] <= quo_in;
         end
      end
   end

   // sign, saturation and zeroing of singular items
   always_comb begin
      out_valid = vld_ff[Steps];
      out_sing  = sng_ff[Steps];
      for (int l = 0; l < Lanes; l++) begin
         logic [Steps-1:0] q;
         q = quo_ff[Steps][l];
         if (sng_ff[Steps]) begin
            out_q[l] = '0;
         end else if (neg_ff[Steps][l]) begin
            if (q > Steps'(33'h80000000)) out_q[l] = 32'h80000000;
            else out_q[l] = 32'(Steps'(0) - q);
         end else begin
            if (q > Steps'(32'h7FFFFFFF)) out_q[l] = 32'h7FFFFFFF;
            else out_q[l] = q[31:0];
         end
      end
   end

endmodule
